@@ design/ssui_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssui_pkg
// Shared types, codes and helpers of the segmented sort/unique index block.
// ----------------------------------------------------------------------------
package ssui_pkg;

  localparam int ROW_W  = 12;
  localparam int VAL_W  = 32;
  localparam int OFF_W  = 32;
  localparam int ACT_W  = 2;
  localparam int KIND_W = 2;

  localparam int COLUMN_DEPTH_DEF = 4096;
  localparam int GROUP_DEPTH_DEF  = 32;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MEMBER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLOSE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FINISH = 2'd3;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [OFF_W-1:0]        offset;
    logic signed [VAL_W-1:0] value_res;
    logic                    last;
    logic                    overflow;
  } out_item_t;

  // Six restoring-reduction steps of row modulo depth, shifts base down to base-5.
  function automatic logic [ROW_W-1:0] wrap_steps(input logic [ROW_W-1:0] r,
                                                  input logic [31:0] d,
                                                  input int base);
    logic [ROW_W-1:0] acc;
    logic [31:0]      t;
    int               k;
    acc = r;
    for (int j = 0; j < 6; j++) begin
      k = base - j;
      t = d << k;
      if (t <= {{(32-ROW_W){1'b0}}, acc}) begin
        acc = acc - t[ROW_W-1:0];
      end
    end
    return acc;
  endfunction

endpackage

@@ design/ssui_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssui_stream_if
// Valid/ready channel carrying one beat of payload type T.
// ----------------------------------------------------------------------------
interface ssui_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/segmented_sort_unique_index.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_sort_unique_index
// Column store plus sorted, deduplicated group buffer emitting an inverted index.
// ----------------------------------------------------------------------------
// Input beats on in_i: load (writes a column row), member (gathers a row into
// the group), close (emits the group), finish (emits the total, clears offset).
// Output beats on out_o carry start offsets, sorted unique values and totals;
// last marks the final beat caused by one input beat.
// Sequencing, from the accept state: a load writes the column RAM in S_ADDR.
// A member reads the column (S_ADDR, S_GET), then walks buffer entries in the
// ascending insertion scan (S_SCAN) and the shift that follows it (S_SHIFT), up
// to GROUP_DEPTH entries, paced by the single read port of the group buffer RAM.
// A close emits the offset beat (S_START), then reads back each value (S_RD,
// S_EMIT); a finish emits the total (S_TOTAL). in_i.ready is high only between items.
// Reset clears the group count, running offset and overflow flag; the column
// and group RAMs are not cleared. When out_o stalls the current beat holds in
// the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module segmented_sort_unique_index #(
  parameter int COLUMN_DEPTH = ssui_pkg::COLUMN_DEPTH_DEF,
  parameter int GROUP_DEPTH  = ssui_pkg::GROUP_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssui_stream_if.sink   in_i,
  ssui_stream_if.source out_o
);

  localparam int CW = $clog2(COLUMN_DEPTH);
  localparam int GW = $clog2(GROUP_DEPTH);
  localparam int NW = $clog2(GROUP_DEPTH + 1);
  localparam int VW = ssui_pkg::VAL_W;
  localparam int OW = ssui_pkg::OFF_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADDR  = 4'd1;
  localparam logic [3:0] S_GET   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_START = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_TOTAL = 4'd8;

  logic [3:0]                  state_q, state_d;
  logic [ssui_pkg::ACT_W-1:0]  act_q, act_d;
  logic [ssui_pkg::ROW_W-1:0]  rowr_q, rowr_d;
  logic [VW-1:0]               val_q, val_d;
  logic [VW-1:0]               v_q, v_d;
  logic [NW-1:0]               cnt_q, cnt_d;
  logic [OW-1:0]               off_q, off_d;
  logic [OW-1:0]               next_off_q, next_off_d;
  logic                        ovf_seen_q, ovf_seen_d;
  logic                        close_ovf_q, close_ovf_d;
  logic [GW-1:0]               ptr_q, ptr_d;
  logic [GW-1:0]               idx_q, idx_d;
  ssui_pkg::out_item_t         out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic          col_we, col_re;
  logic [CW-1:0] col_addr;
  logic [VW-1:0] col_rdata;
  logic          grp_we, grp_re;
  logic [GW-1:0] grp_waddr, grp_raddr;
  logic [VW-1:0] grp_wdata, grp_rdata;

  logic          in_fire, slot, full;
  logic [OW:0]   close_sum, pos_sum;
  logic [OW-1:0] pos_sat;

  ssui_ram #(.DEPTH(COLUMN_DEPTH), .WIDTH(VW), .AW(CW)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_addr),
    .wdata_i (val_q),
    .re_i    (col_re),
    .raddr_i (col_addr),
    .rdata_o (col_rdata)
  );

  ssui_ram #(.DEPTH(GROUP_DEPTH), .WIDTH(VW), .AW(GW)) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (grp_we),
    .waddr_i (grp_waddr),
    .wdata_i (grp_wdata),
    .re_i    (grp_re),
    .raddr_i (grp_raddr),
    .rdata_o (grp_rdata)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign slot        = !out_valid_q || out_o.ready;
  assign full        = (cnt_q == NW'(GROUP_DEPTH));
  assign close_sum   = {1'b0, off_q} + (OW + 1)'(cnt_q);
  assign pos_sum     = {1'b0, off_q} + (OW + 1)'(idx_q);
  assign pos_sat     = pos_sum[OW] ? {OW{1'b1}} : pos_sum[OW-1:0];
  assign col_addr    = CW'(ssui_pkg::wrap_steps(rowr_q, 32'(COLUMN_DEPTH), 5));
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    rowr_d      = rowr_q;
    val_d       = val_q;
    v_d         = v_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    next_off_d  = next_off_q;
    ovf_seen_d  = ovf_seen_q;
    close_ovf_d = close_ovf_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    col_we      = 1'b0;
    col_re      = 1'b0;
    grp_we      = 1'b0;
    grp_re      = 1'b0;
    grp_waddr   = '0;
    grp_wdata   = v_q;
    grp_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          act_d  = in_i.data.action;
          rowr_d = ssui_pkg::wrap_steps(in_i.data.row, 32'(COLUMN_DEPTH), 11);
          val_d  = in_i.data.value;
          case (in_i.data.action)
            ssui_pkg::ACT_CLOSE:  state_d = S_START;
            ssui_pkg::ACT_FINISH: state_d = S_TOTAL;
            default:              state_d = S_ADDR;
          endcase
        end
      end
      S_ADDR: begin
        if (act_q == ssui_pkg::ACT_LOAD) begin
          col_we  = 1'b1;
          state_d = S_IDLE;
        end else begin
          col_re  = 1'b1;
          state_d = S_GET;
        end
      end
      S_GET: begin
        v_d = col_rdata;
        if (cnt_q == '0) begin
          grp_we    = 1'b1;
          grp_wdata = col_rdata;
          cnt_d     = NW'(1);
          state_d   = S_IDLE;
        end else begin
          grp_re    = 1'b1;
          grp_raddr = '0;
          ptr_d     = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (grp_rdata == v_q) begin
          state_d = S_IDLE;
        end else if ($signed(grp_rdata) < $signed(v_q)) begin
          if ((NW'(ptr_q) + NW'(1)) == cnt_q) begin
            if (full) begin
              ovf_seen_d = 1'b1;
            end else begin
              grp_we    = 1'b1;
              grp_waddr = GW'(cnt_q);
              cnt_d     = cnt_q + NW'(1);
            end
            state_d = S_IDLE;
          end else begin
            grp_re    = 1'b1;
            grp_raddr = ptr_q + GW'(1);
            ptr_d     = ptr_q + GW'(1);
          end
        end else begin
          if (full) begin
            ovf_seen_d = 1'b1;
            state_d    = S_IDLE;
          end else begin
            grp_we    = 1'b1;
            grp_waddr = ptr_q;
            v_d       = grp_rdata;
            grp_re    = 1'b1;
            grp_raddr = ptr_q + GW'(1);
            ptr_d     = ptr_q + GW'(1);
            state_d   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        grp_we    = 1'b1;
        grp_waddr = ptr_q;
        if (NW'(ptr_q) == cnt_q) begin
          cnt_d   = cnt_q + NW'(1);
          state_d = S_IDLE;
        end else begin
          v_d       = grp_rdata;
          grp_re    = 1'b1;
          grp_raddr = ptr_q + GW'(1);
          ptr_d     = ptr_q + GW'(1);
        end
      end
      S_START: begin
        if (slot) begin
          next_off_d      = close_sum[OW] ? {OW{1'b1}} : close_sum[OW-1:0];
          close_ovf_d     = ovf_seen_q || close_sum[OW];
          out_valid_d     = 1'b1;
          out_d.kind      = ssui_pkg::KIND_START;
          out_d.offset    = off_q;
          out_d.value_res = '0;
          out_d.last      = (cnt_q == '0);
          out_d.overflow  = ovf_seen_q || close_sum[OW];
          idx_d           = '0;
          if (cnt_q == '0) begin
            off_d      = close_sum[OW] ? {OW{1'b1}} : close_sum[OW-1:0];
            ovf_seen_d = 1'b0;
            state_d    = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        grp_re    = 1'b1;
        grp_raddr = idx_q;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (slot) begin
          out_valid_d     = 1'b1;
          out_d.kind      = ssui_pkg::KIND_VALUE;
          out_d.offset    = pos_sat;
          out_d.value_res = grp_rdata;
          out_d.last      = ((NW'(idx_q) + NW'(1)) == cnt_q);
          out_d.overflow  = close_ovf_q;
          if ((NW'(idx_q) + NW'(1)) == cnt_q) begin
            off_d      = next_off_q;
            cnt_d      = '0;
            ovf_seen_d = 1'b0;
            state_d    = S_IDLE;
          end else begin
            idx_d   = idx_q + GW'(1);
            state_d = S_RD;
          end
        end
      end
      S_TOTAL: begin
        if (slot) begin
          out_valid_d     = 1'b1;
          out_d.kind      = ssui_pkg::KIND_TOTAL;
          out_d.offset    = off_q;
          out_d.value_res = '0;
          out_d.last      = 1'b1;
          out_d.overflow  = 1'b0;
          off_d           = '0;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      off_q       <= '0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      off_q       <= off_d;
      ovf_seen_q  <= ovf_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    rowr_q      <= rowr_d;
    val_q       <= val_d;
    v_q         <= v_d;
    next_off_q  <= next_off_d;
    close_ovf_q <= close_ovf_d;
    ptr_q       <= ptr_d;
    idx_q       <= idx_d;
    out_q       <= out_d;
  end

endmodule

@@ design/ssui_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssui_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssui_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
